// ----- hdl/cmaa_pkg.sv -----
// shared types and constants of the centered moving average alert block
package cmaa_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int POS_W     = 16;
  localparam int RADIUS_FW = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_LEVEL = 1'b1;

  localparam int                          RADIUS_RST = 1;
  localparam logic signed [SAMPLE_W-1:0] ALERT_RST  = 16'sh7FFF;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smooth_value;
    logic        [POS_W-1:0]    position;
    logic                       alert;
    logic                       last_result;
  } out_t;

endpackage

// ----- hdl/cmaa_ram.sv -----
// generic single write port ram with registered read
module cmaa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/cmaa_alu.sv -----
// shared add/subtract unit used for accumulation, sign handling and division steps
module cmaa_alu #(
  parameter int W = 22
) (
  input  cmaa_pkg::alu_op_e op_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output logic [W-1:0]      y_o
);

  always_comb begin
    case (op_i)
      cmaa_pkg::ALU_ADD: y_o = a_i + b_i;
      cmaa_pkg::ALU_SUB: y_o = a_i - b_i;
      default:           y_o = a_i + b_i;
    endcase
  end

endmodule

// ----- hdl/centered_moving_average_alert_top.sv -----
// top level of the centered moving average alert block
//
// Smooths a record of signed Q3.12 samples with a centered window of
// +/- radius samples, clipped at both record edges, and flags averages
// above alert_level. One result comes out per position, radius samples
// after the sample it is centered on; the sample marked last_sample
// flushes every pending position and restarts the record. The block
// takes one sample at a time and drops in_ready_o until everything that
// sample releases has been computed. Each result is worked out by one
// shared add/subtract unit under a small sequencer: the window is summed
// from the sample ring with one read and one add per sample in the
// window, then divided by the window size with a restoring divider
// that takes one quotient bit per cycle. The sum is SUM_W bits wide,
// SUM_W = 16 + clog2(2*MAX_RADIUS+1), i.e. 22 at the default MAX_RADIUS.
// A result waits in the output register while the next sample is taken;
// the sequencer only stalls when a new result finds the output register
// still full. Configuration writes are accepted every cycle and are meant
// for idle periods.
module centered_moving_average_alert_top #(
  parameter int MAX_RADIUS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  cmaa_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output cmaa_pkg::out_t                       out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cmaa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cmaa_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  // sample ring depth and derived widths
  localparam int HIST   = 2 * MAX_RADIUS + 1;
  localparam int PTR_W  = $clog2(HIST);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int PEND_W = $clog2(MAX_RADIUS + 2);
  localparam int CNT_W  = $clog2(HIST + 1);
  localparam int IW     = PTR_W + 1;
  localparam int SUM_W  = cmaa_pkg::SAMPLE_W + $clog2(HIST);
  localparam int DC_W   = $clog2(SUM_W);
  localparam int SW     = cmaa_pkg::SAMPLE_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_ABS   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_NEG   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // control state
  logic [2:0]              state_q, state_d;
  logic [RAD_W-1:0]        radius_q, radius_d;
  logic signed [SW-1:0]    alert_lvl_q, alert_lvl_d;
  logic [PTR_W-1:0]        wp_q, wp_d;         // ring slot of the next sample
  logic [PTR_W-1:0]        pp_q, pp_d;         // ring slot of the next center
  logic [cmaa_pkg::POS_W-1:0] np_q, np_d;      // next center position
  logic [RAD_W-1:0]        psat_q, psat_d;     // next center, saturated at MAX_RADIUS
  logic [PEND_W-1:0]       a_q, a_d;           // centers still waiting for a result
  logic                    last_q, last_d;
  logic [PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]        rem_cnt_q, rem_cnt_d;
  logic [DC_W-1:0]         div_cnt_q, div_cnt_d;
  logic                    out_valid_q, out_valid_d;

  // datapath registers
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0]        dq_q, dq_d;         // dividend shifting out, quotient shifting in
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic                    neg_q, neg_d;
  logic signed [SW-1:0]    avg_q, avg_d;
  logic                    alert_q, alert_d;
  cmaa_pkg::out_t          out_q, out_d;

  // shared unit and ring
  cmaa_pkg::alu_op_e       alu_op;
  logic [SUM_W-1:0]        alu_a, alu_b, alu_y;
  logic                    ram_we, ram_re;
  logic [SW-1:0]           ram_rdata;

  // window geometry
  logic                    in_acc;
  logic                    out_free;
  logic                    out_load;
  logic [CNT_W-1:0]        r_c, ps_c, d_c, left_c, right_c, win_c;
  logic                    emit_go;
  logic [IW-1:0]           pp_x, left_x, start_x;
  logic [CNT_W:0]          trial;
  logic                    qbit;
  logic [RAD_W-1:0]        rad_sat;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // left reach is clipped by the record start, right reach by the newest sample
  assign r_c     = CNT_W'(radius_q);
  assign ps_c    = CNT_W'(psat_q);
  assign d_c     = CNT_W'(a_q - 1'b1);
  assign left_c  = (ps_c < r_c) ? ps_c : r_c;
  assign right_c = (d_c < r_c) ? d_c : r_c;
  assign win_c   = left_c + right_c + 1'b1;
  assign emit_go = (a_q != '0) && (last_q || (d_c >= r_c));

  // first ring slot of the window, modulo the ring depth
  assign pp_x    = IW'(pp_q);
  assign left_x  = IW'(left_c);
  assign start_x = (pp_x >= left_x) ? (pp_x - left_x) : (pp_x + IW'(HIST) - left_x);

  // restoring division step: partial remainder with the next dividend bit
  assign trial = {rem_q, dq_q[SUM_W-1]};

  // radius write saturates at MAX_RADIUS
  assign rad_sat = (32'(cfg_data_i[cmaa_pkg::RADIUS_FW-1:0]) > 32'(MAX_RADIUS))
                   ? RAD_W'(MAX_RADIUS)
                   : RAD_W'(cfg_data_i[cmaa_pkg::RADIUS_FW-1:0]);

  cmaa_ram #(
    .WIDTH (SW),
    .DEPTH (HIST)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_data_i.sample),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  cmaa_alu #(
    .W (SUM_W)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  always_comb begin
    state_d     = state_q;
    radius_d    = radius_q;
    alert_lvl_d = alert_lvl_q;
    wp_d        = wp_q;
    pp_d        = pp_q;
    np_d        = np_q;
    psat_d      = psat_q;
    a_d         = a_q;
    last_d      = last_q;
    rd_ptr_d    = rd_ptr_q;
    rem_cnt_d   = rem_cnt_q;
    div_cnt_d   = div_cnt_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    avg_d       = avg_q;
    alert_d     = alert_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    alu_op      = cmaa_pkg::ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    qbit        = 1'b0;
    out_load    = 1'b0;

    // register writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        cmaa_pkg::CFG_RADIUS:      radius_d = rad_sat;
        cmaa_pkg::CFG_ALERT_LEVEL: alert_lvl_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        // store the sample in the ring, one more center is now pending
        if (in_acc) begin
          ram_we  = 1'b1;
          wp_d    = (wp_q == PTR_W'(HIST - 1)) ? '0 : wp_q + 1'b1;
          a_d     = a_q + 1'b1;
          last_d  = in_data_i.last_sample;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (emit_go) begin
          rd_ptr_d  = start_x[PTR_W-1:0];
          rem_cnt_d = win_c;
          cnt_d     = win_c;
          sum_d     = '0;
          state_d   = S_READ;
        end else begin
          // end of record: start the next one from position zero
          if (last_q) begin
            wp_d   = '0;
            pp_d   = '0;
            np_d   = '0;
            psat_d = '0;
            a_d    = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        rd_ptr_d  = (rd_ptr_q == PTR_W'(HIST - 1)) ? '0 : rd_ptr_q + 1'b1;
        rem_cnt_d = rem_cnt_q - 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        alu_op  = cmaa_pkg::ALU_ADD;
        alu_a   = sum_q;
        alu_b   = SUM_W'($signed(ram_rdata));
        sum_d   = alu_y;
        state_d = (rem_cnt_q == '0) ? S_ABS : S_READ;
      end
      S_ABS: begin
        // divide magnitudes, fix the sign afterwards (truncation toward zero)
        alu_op    = cmaa_pkg::ALU_SUB;
        alu_a     = '0;
        alu_b     = sum_q;
        neg_d     = sum_q[SUM_W-1];
        dq_d      = sum_q[SUM_W-1] ? alu_y : sum_q;
        rem_d     = '0;
        div_cnt_d = DC_W'(SUM_W - 1);
        state_d   = S_DIV;
      end
      S_DIV: begin
        alu_op = cmaa_pkg::ALU_SUB;
        alu_a  = SUM_W'(trial);
        alu_b  = SUM_W'(cnt_q);
        if (!alu_y[SUM_W-1]) begin
          rem_d = alu_y[CNT_W-1:0];
          qbit  = 1'b1;
        end else begin
          rem_d = trial[CNT_W-1:0];
          qbit  = 1'b0;
        end
        dq_d      = {dq_q[SUM_W-2:0], qbit};
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          state_d = S_NEG;
        end
      end
      S_NEG: begin
        alu_op  = cmaa_pkg::ALU_SUB;
        alu_a   = '0;
        alu_b   = dq_q;
        avg_d   = neg_q ? alu_y[SW-1:0] : dq_q[SW-1:0];
        alert_d = (avg_d > alert_lvl_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        // hand over once the output register is free, then advance the center
        if (out_free) begin
          out_load = 1'b1;
          np_d     = np_q + 1'b1;
          psat_d   = (psat_q == RAD_W'(MAX_RADIUS)) ? psat_q : psat_q + 1'b1;
          pp_d     = (pp_q == PTR_W'(HIST - 1)) ? '0 : pp_q + 1'b1;
          a_d      = a_q - 1'b1;
          state_d  = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_d.smooth_value = avg_q;
    out_d.position     = np_q;
    out_d.alert        = alert_q;
    out_d.last_result  = last_q && (a_q == PEND_W'(1));
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= RAD_W'(cmaa_pkg::RADIUS_RST);
      alert_lvl_q <= cmaa_pkg::ALERT_RST;
      wp_q        <= '0;
      pp_q        <= '0;
      np_q        <= '0;
      psat_q      <= '0;
      a_q         <= '0;
      last_q      <= 1'b0;
      rd_ptr_q    <= '0;
      rem_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radius_q    <= radius_d;
      alert_lvl_q <= alert_lvl_d;
      wp_q        <= wp_d;
      pp_q        <= pp_d;
      np_q        <= np_d;
      psat_q      <= psat_d;
      a_q         <= a_d;
      last_q      <= last_d;
      rd_ptr_q    <= rd_ptr_d;
      rem_cnt_q   <= rem_cnt_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    sum_q   <= sum_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    avg_q   <= avg_d;
    alert_q <= alert_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/cmaa_checker.sv -----
// port level checks of the centered moving average alert block and their binding
module cmaa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cmaa_pkg::out_t out_data_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // in_ready_o drops in the cycle after each accepted sample, the sequencer being busy with it
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample taken in back to back cycles");

  // a new result appears only while the sequencer is busy with a sample
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("result appeared while idle");

  // the most negative average can never exceed any threshold
  a_alert_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.alert |-> out_data_o.smooth_value != 16'sh8000)
    else $error("alert on minimum average");

endmodule

bind centered_moving_average_alert_top cmaa_checker u_cmaa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- test/centered_moving_average_alert_top_tb.sv -----
// testbench of the centered moving average alert block: predictor, driver, monitor
module centered_moving_average_alert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RADIUS  = 16;
  localparam int RING_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 100;

  // dut ports; the inputs are known from time zero
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  cmaa_pkg::in_t                  in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  cmaa_pkg::out_t                 out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [cmaa_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [cmaa_pkg::CFG_DAT_W-1:0] cfg_data_i  = '0;

  // stimulus and expectations
  cmaa_pkg::in_t  sample_q[$];          // samples waiting for the driver
  cmaa_pkg::out_t pending_averages[$];  // predicted results, oldest first
  int   samples_in_flight = 0; // queued but not yet transferred
  int   errors = 0;
  int   cycle_cnt = 0;

  // idling knobs, percent of cycles
  int   send_idle_pct = 0;
  int   rcv_idle_pct  = 30;

  // long receiver hold-off
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  // predictor copy of the block's configuration and record state
  int unsigned             radius_now = cmaa_pkg::RADIUS_RST;
  logic signed [15:0]      level_now  = cmaa_pkg::ALERT_RST;
  logic signed [cmaa_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
  int unsigned             seen_cnt = 0;
  int unsigned             next_pos = 0;

  // random record shaping
  int rec_left  = 0;
  int rec_style = 0;

  centered_moving_average_alert_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_record();
    foreach (ring[i]) ring[i] = '0;
    seen_cnt = 0;
    next_pos = 0;
  endfunction

  // average of the window around position p, clipped to 0 .. newest
  function automatic cmaa_pkg::out_t window_average(int unsigned p, int unsigned newest,
                                                    bit fin);
    int unsigned    lo;
    int unsigned    hi;
    int             acc;
    int             cnt;
    int             avg;
    cmaa_pkg::out_t r;
    lo  = (p >= radius_now) ? p - radius_now : 0;
    hi  = p + radius_now;
    if (hi > newest) hi = newest;
    acc = 0;
    cnt = 0;
    for (int unsigned j = lo; j <= hi; j++) begin
      acc += ring[j % RING_DEPTH];
      cnt++;
    end
    // integer division truncates toward zero, as the block does
    avg = acc / cnt;
    r.smooth_value = avg[15:0];
    r.position     = p[15:0];
    r.alert        = (avg > level_now);
    r.last_result  = fin;
    return r;
  endfunction

  // take one sample and queue every average that it releases
  task automatic smooth_sample(input cmaa_pkg::in_t it);
    int unsigned n;
    int          k;
    n = seen_cnt;
    k = 0;
    ring[n % RING_DEPTH] = it.sample;
    if (it.last_sample) begin
      // end of record: flush every pending position
      while (k < MAX_RADIUS + 1 && next_pos <= n) begin
        pending_averages.push_back(window_average(next_pos, n, next_pos == n));
        next_pos++;
        k++;
      end
      clear_record();
    end else begin
      // a position is ready once radius samples past it are in
      while (k < MAX_RADIUS + 1 && next_pos <= n && n - next_pos >= radius_now) begin
        pending_averages.push_back(window_average(next_pos, n, 1'b0));
        next_pos++;
        k++;
      end
      seen_cnt = n + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one sample transfer per handshake, random gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        smooth_sample(in_data_i);
        samples_in_flight--;
      end
      // valid stays up with the same payload until the transfer
      if (!in_valid_i || in_ready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result transfer with the oldest prediction
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    cmaa_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_averages.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %p", $time, out_data_o);
      end else begin
        want = pending_averages.pop_front();
        check_field("smooth_value", want.smooth_value, out_data_o.smooth_value);
        check_field("position", want.position, out_data_o.position);
        check_field("alert", want.alert, out_data_o.alert);
        check_field("last_result", want.last_result, out_data_o.last_result);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_sample(input logic [15:0] value, input logic fin);
    cmaa_pkg::in_t it;
    it.sample      = value;
    it.last_sample = fin;
    sample_q.push_back(it);
    samples_in_flight++;
  endtask

  // wait until every sample is transferred and every average has arrived,
  // then give a sample that released nothing time to retire
  task automatic settle();
    while (samples_in_flight != 0 || pending_averages.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cmaa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cmaa_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == cmaa_pkg::CFG_RADIUS) begin
      // radius field is 5 bits, saturated to the ring's reach
      radius_now = (val[4:0] > MAX_RADIUS) ? MAX_RADIUS : val[4:0];
    end else begin
      level_now = val;
    end
  endtask

  // random records: mostly short ones, now and then a long one, each with
  // its own flavor of samples so alerts and clipping both get exercised
  task automatic queue_records(input int count);
    int v;
    repeat (count) begin
      if (rec_left == 0) begin
        rec_left  = ($urandom_range(9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 12);
        rec_style = $urandom_range(3);
      end
      case (rec_style)
        0:       v = $urandom_range(65535);
        1:       v = int'(level_now) + int'($urandom_range(4096)) - 2048;
        2:       v = $urandom_range(1) ? 32'h7FFF - $urandom_range(3) : 32'h8000 + $urandom_range(3);
        default: v = int'($urandom_range(16383)) - 8192;
      endcase
      rec_left--;
      push_sample(v[15:0], rec_left == 0);
    end
  endtask

  task automatic set_idling(input int send_pct, input int rcv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    rcv_idle_pct  <= rcv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_record();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: radius 1, no alert possible; sample extremes and
    // a one-sample record
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h7FFF, 1'b1);
    push_sample(16'h1234, 1'b1);
    settle();

    // radius 0 passes samples straight through; lowest alert level
    write_reg(cmaa_pkg::CFG_RADIUS, 16'h0000);
    write_reg(cmaa_pkg::CFG_ALERT_LEVEL, 16'h8000);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    settle();

    // radius above the maximum saturates; then shrink it mid-record so one
    // sample releases a burst, then widen it again before the end
    write_reg(cmaa_pkg::CFG_RADIUS, 16'h001F);
    write_reg(cmaa_pkg::CFG_ALERT_LEVEL, 16'h0000);
    push_sample(16'h4000, 1'b0);
    push_sample(16'hC000, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0100, 1'b0);
    settle();
    write_reg(cmaa_pkg::CFG_RADIUS, 16'hFFE0);  // upper bits ignored, radius 0
    push_sample(16'h0ABC, 1'b0);
    settle();
    write_reg(cmaa_pkg::CFG_RADIUS, 16'h0002);
    push_sample(16'h5555, 1'b0);
    push_sample(16'hAAAA, 1'b1);
    settle();

    // full radius, alert just under the top
    write_reg(cmaa_pkg::CFG_RADIUS, 16'h0010);
    write_reg(cmaa_pkg::CFG_ALERT_LEVEL, 16'h7FFE);
    repeat (3) push_sample(16'h7FFF, 1'b0);
    push_sample(16'h7FFF, 1'b1);
    settle();

    // random phase one: small radius, sender mostly busy, receiver slow
    write_reg(cmaa_pkg::CFG_RADIUS, 16'($urandom_range(3)));
    write_reg(cmaa_pkg::CFG_ALERT_LEVEL, 16'(int'($urandom_range(16383)) - 8192));
    set_idling(15, 82);
    queue_records(37);
    settle();

    // phase two: wide radius, records left open across the change
    write_reg(cmaa_pkg::CFG_RADIUS, 16'($urandom_range(4, 31)));
    write_reg(cmaa_pkg::CFG_ALERT_LEVEL, 16'($urandom_range(65535)));
    set_idling(82, 15);
    queue_records(37);
    settle();

    // phase three: no idling, receiver holds off long enough to back up
    // the block while samples keep coming
    write_reg(cmaa_pkg::CFG_RADIUS, 16'($urandom_range(31)));
    write_reg(cmaa_pkg::CFG_ALERT_LEVEL, 16'(int'($urandom_range(16383)) - 8192));
    set_idling(0, 0);
    hold_req <= 1'b1;
    queue_records(36);
    if (rec_left != 0) begin
      push_sample(16'($urandom_range(65535)), 1'b1);
    end
    settle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
